FILE: design/pipt_pkg.sv
package pipt_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int COUNT_W = $clog2(MAX_VERTICES + 1);

  localparam int COORD_W = 16;
  localparam int SH_W = COORD_W + 1;
  localparam int DIF_W = COORD_W + 2;
  localparam int PROD_W = 2 * DIF_W;
  localparam int QUO_W = DIF_W;
  localparam int STEP_W = $clog2(QUO_W);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_TEST   = 2'd2
  } op_t;

  typedef struct packed {
    logic done;
    logic busy;
  } div_stat_t;

endpackage

FILE: design/polygon_point_inclusion_test_unit.sv
// Append, clear and unused beats, and tests outside the box, register their result on acceptance.
// A test inside the box reads the closing vertex, then per edge fetches, loads and checks it, running the
// 18-step divider on each edge needing an intercept; the vertex memory read is registered.
// One beat is in flight at a time; the next beat is taken once the result is registered and the output is free.
// Reset empties the vertex store by zeroing the count and clears the bounding box;
// the vertex memory itself is not cleared.
module polygon_point_inclusion_test_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             op,
  input  logic signed [pipt_pkg::COORD_W-1:0]    x,
  input  logic signed [pipt_pkg::COORD_W-1:0]    y,
  input  logic signed [pipt_pkg::COORD_W-1:0]    offset_x,
  input  logic signed [pipt_pkg::COORD_W-1:0]    offset_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   inside_res,
  output logic                                   status,
  output logic [pipt_pkg::COUNT_W-1:0]           vertex_count
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_FETCHJ = 9'b000000010,
    ST_LOADJ  = 9'b000000100,
    ST_FETCH  = 9'b000001000,
    ST_LOAD   = 9'b000010000,
    ST_CALC   = 9'b000100000,
    ST_DIVS   = 9'b001000000,
    ST_DIVW   = 9'b010000000,
    ST_RESULT = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [2*pipt_pkg::COORD_W-1:0] mem [pipt_pkg::MAX_VERTICES];
  logic [2*pipt_pkg::COORD_W-1:0] rdata;
  logic [pipt_pkg::ADDR_W-1:0]    raddr;

  logic [pipt_pkg::COUNT_W-1:0]   count;
  logic signed [pipt_pkg::COORD_W-1:0] box_min_x, box_max_x, box_min_y, box_max_y;
  logic signed [pipt_pkg::COORD_W-1:0] px, py, ox, oy;
  logic signed [pipt_pkg::SH_W-1:0] xi, yi, xj, yj;
  logic [pipt_pkg::COUNT_W-1:0]   idx;
  logic                           in_poly;
  logic signed [pipt_pkg::PROD_W-1:0] num;
  logic signed [pipt_pkg::DIF_W-1:0]  den;

  logic                           accept;
  logic                           out_free;
  logic                           in_box;
  logic                           crosses;
  logic                           left;
  logic                           last_edge;
  logic signed [pipt_pkg::DIF_W-1:0] dn, dx;
  logic signed [pipt_pkg::QUO_W+1:0] xint;
  logic signed [pipt_pkg::SH_W-1:0]  rx, ry;

  pipt_pkg::div_stat_t            div_stat;
  logic signed [pipt_pkg::QUO_W:0] quo;

  pipt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_DIVS),
    .num   (num),
    .den   (den),
    .stat  (div_stat),
    .quo   (quo)
  );

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || !out_free;
  assign accept = in_valid && !in_stall;

  assign in_box = (count != '0) && (box_min_x < x) && (box_max_x > x) &&
                  (box_min_y < y) && (box_max_y > y);

  assign rx = pipt_pkg::SH_W'($signed(rdata[2*pipt_pkg::COORD_W-1:pipt_pkg::COORD_W])) +
              pipt_pkg::SH_W'(ox);
  assign ry = pipt_pkg::SH_W'($signed(rdata[pipt_pkg::COORD_W-1:0])) + pipt_pkg::SH_W'(oy);

  assign crosses = (yi < py && yj >= py) || (yj < py && yi >= py);
  assign left = (xi <= px) || (xj <= px);
  assign dn = pipt_pkg::DIF_W'(py) - pipt_pkg::DIF_W'(yi);
  assign dx = pipt_pkg::DIF_W'(xj) - pipt_pkg::DIF_W'(xi);
  assign xint = (pipt_pkg::QUO_W+2)'(xi) + (pipt_pkg::QUO_W+2)'(quo);
  assign last_edge = (idx + 1'b1) == count;

  assign raddr = (state == ST_FETCHJ) ? pipt_pkg::ADDR_W'(count - 1'b1)
                                      : idx[pipt_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (accept && op == pipt_pkg::OP_APPEND && count < pipt_pkg::COUNT_W'(pipt_pkg::MAX_VERTICES))
      mem[count[pipt_pkg::ADDR_W-1:0]] <= {x, y};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept && op == pipt_pkg::OP_TEST && in_box) state_next = ST_FETCHJ;
      ST_FETCHJ: state_next = ST_LOADJ;
      ST_LOADJ:  state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_CALC;
      ST_CALC: begin
        if (crosses && left) state_next = ST_DIVS;
        else state_next = last_edge ? ST_RESULT : ST_FETCH;
      end
      ST_DIVS:   state_next = ST_DIVW;
      ST_DIVW:   if (div_stat.done) state_next = last_edge ? ST_RESULT : ST_FETCH;
      ST_RESULT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      box_min_x <= '0;
      box_max_x <= '0;
      box_min_y <= '0;
      box_max_y <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && !(op == pipt_pkg::OP_TEST && in_box)) out_valid <= 1'b1;
      else if (state == ST_RESULT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept) begin
        case (op)
          pipt_pkg::OP_APPEND: begin
            if (count < pipt_pkg::COUNT_W'(pipt_pkg::MAX_VERTICES)) begin
              count <= count + 1'b1;
              if (count == '0) begin
                box_min_x <= x;
                box_max_x <= x;
                box_min_y <= y;
                box_max_y <= y;
              end else begin
                if (x > box_max_x) box_max_x <= x;
                else if (box_min_x > x) box_min_x <= x;
                if (y > box_max_y) box_max_y <= y;
                else if (box_min_y > y) box_min_y <= y;
              end
            end
          end
          pipt_pkg::OP_CLEAR: count <= '0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px <= x;
      py <= y;
      ox <= offset_x;
      oy <= offset_y;
      idx <= '0;
      in_poly <= 1'b0;
      inside_res <= 1'b0;
      status <= (op == pipt_pkg::OP_APPEND) &&
                (count >= pipt_pkg::COUNT_W'(pipt_pkg::MAX_VERTICES));
      case (op)
        pipt_pkg::OP_APPEND:
          vertex_count <= (count < pipt_pkg::COUNT_W'(pipt_pkg::MAX_VERTICES)) ?
                          count + 1'b1 : count;
        pipt_pkg::OP_CLEAR: vertex_count <= '0;
        default: vertex_count <= count;
      endcase
    end
    if (state == ST_LOADJ) begin
      xj <= rx;
      yj <= ry;
    end
    if (state == ST_LOAD) begin
      xi <= rx;
      yi <= ry;
    end
    if (state == ST_CALC) begin
      num <= dn * dx;
      den <= pipt_pkg::DIF_W'(yj) - pipt_pkg::DIF_W'(yi);
    end
    // The current vertex becomes the previous one once its edge is settled.
    if ((state == ST_CALC && !(crosses && left)) || (state == ST_DIVW && div_stat.done)) begin
      xj <= xi;
      yj <= yi;
      idx <= idx + 1'b1;
    end
    if (state == ST_DIVW && div_stat.done && xint < (pipt_pkg::QUO_W+2)'(px))
      in_poly <= !in_poly;
    if (state == ST_RESULT && out_free) begin
      inside_res <= in_poly;
      status <= 1'b0;
      vertex_count <= count;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> state == ST_IDLE)
    else $error("beat accepted while a test is running");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= pipt_pkg::COUNT_W'(pipt_pkg::MAX_VERTICES))
    else $error("vertex count beyond the store depth");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIVW)
    else $error("divider finished outside the wait state");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_FETCH |-> idx < count)
    else $error("edge index ran past the vertex count");
`endif

endmodule

FILE: design/pipt_div.sv
module pipt_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [pipt_pkg::PROD_W-1:0]    num,
  input  logic signed [pipt_pkg::DIF_W-1:0]     den,
  output pipt_pkg::div_stat_t                   stat,
  output logic signed [pipt_pkg::QUO_W:0]       quo
);

  logic                          busy;
  logic                          done;
  logic [pipt_pkg::STEP_W-1:0]   step;
  logic                          neg;
  logic [pipt_pkg::DIF_W-1:0]    den_mag;
  logic [pipt_pkg::DIF_W-1:0]    rem;
  logic [pipt_pkg::QUO_W-1:0]    qacc;
  logic [pipt_pkg::PROD_W-1:0]   num_mag;
  logic [pipt_pkg::DIF_W:0]      trial;
  logic                          take;

  assign num_mag = num[pipt_pkg::PROD_W-1] ? pipt_pkg::PROD_W'(-num) : pipt_pkg::PROD_W'(num);
  assign trial = {rem, qacc[pipt_pkg::QUO_W-1]};
  assign take = trial >= {1'b0, den_mag};

  // The quotient is known to stay below the divisor width, so the upper half of the
  // dividend already sits below the divisor and only the lower bits need steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == pipt_pkg::STEP_W'(pipt_pkg::QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[pipt_pkg::PROD_W-1] ^ den[pipt_pkg::DIF_W-1];
      den_mag <= den[pipt_pkg::DIF_W-1] ? pipt_pkg::DIF_W'(-den) : pipt_pkg::DIF_W'(den);
      rem <= num_mag[pipt_pkg::PROD_W-1:pipt_pkg::QUO_W];
      qacc <= num_mag[pipt_pkg::QUO_W-1:0];
    end else if (busy) begin
      rem <= take ? pipt_pkg::DIF_W'(trial - {1'b0, den_mag}) : trial[pipt_pkg::DIF_W-1:0];
      qacc <= {qacc[pipt_pkg::QUO_W-2:0], take};
    end
  end

  assign quo = neg ? -$signed({1'b0, qacc}) : $signed({1'b0, qacc});
  assign stat.done = done;
  assign stat.busy = busy;

endmodule

FILE: sim/tb_polygon_point_inclusion_test_unit.sv
`timescale 1ns / 100ps

module tb_polygon_point_inclusion_test_unit;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic                          in_poly;
    logic                          full_drop;
    logic [pipt_pkg::COUNT_W-1:0]  held;
  } poly_answer_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] op;
  logic signed [pipt_pkg::COORD_W-1:0] x;
  logic signed [pipt_pkg::COORD_W-1:0] y;
  logic signed [pipt_pkg::COORD_W-1:0] offset_x;
  logic signed [pipt_pkg::COORD_W-1:0] offset_y;
  logic out_valid;
  logic out_stall;
  logic inside_res;
  logic status;
  logic [pipt_pkg::COUNT_W-1:0] vertex_count;

  polygon_point_inclusion_test_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .x(x), .y(y), .offset_x(offset_x), .offset_y(offset_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .inside_res(inside_res), .status(status), .vertex_count(vertex_count)
  );

  // Shadow copy of the polygon held by the block.
  int poly_x [pipt_pkg::MAX_VERTICES];
  int poly_y [pipt_pkg::MAX_VERTICES];
  int poly_len;
  int bmin_x, bmax_x, bmin_y, bmax_y;

  poly_answer_t answer_q[$];
  poly_answer_t answer_seen;
  int error_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic logic ray_cast(input int px, input int py, input int ox, input int oy);
    logic in_flag;
    int j;
    longint xi, yi, xj, yj, xint;
    in_flag = 1'b0;
    if (poly_len == 0) return 1'b0;
    if (!(bmin_x < px && bmax_x > px && bmin_y < py && bmax_y > py)) return 1'b0;
    j = poly_len - 1;
    for (int i = 0; i < poly_len; i++) begin
      xi = poly_x[i] + ox;
      yi = poly_y[i] + oy;
      xj = poly_x[j] + ox;
      yj = poly_y[j] + oy;
      if (((yi < py && yj >= py) || (yj < py && yi >= py)) && (xi <= px || xj <= px)) begin
        xint = xi + ((py - yi) * (xj - xi)) / (yj - yi);
        if (xint < px) in_flag = ~in_flag;
      end
      j = i;
    end
    return in_flag;
  endfunction

  function automatic poly_answer_t predict_answer(input logic [1:0] code, input int px,
                                                  input int py, input int ox, input int oy);
    poly_answer_t r;
    r = '0;
    case (code)
      pipt_pkg::OP_APPEND: begin
        if (poly_len >= pipt_pkg::MAX_VERTICES) begin
          r.full_drop = 1'b1;
        end else begin
          poly_x[poly_len] = px;
          poly_y[poly_len] = py;
          if (poly_len == 0) begin
            bmin_x = px; bmax_x = px; bmin_y = py; bmax_y = py;
          end else begin
            if (px > bmax_x) bmax_x = px;
            else if (bmin_x > px) bmin_x = px;
            if (py > bmax_y) bmax_y = py;
            else if (bmin_y > py) bmin_y = py;
          end
          poly_len++;
        end
      end
      pipt_pkg::OP_CLEAR: poly_len = 0;
      pipt_pkg::OP_TEST:  r.in_poly = ray_cast(px, py, ox, oy);
      default: ;
    endcase
    r.held = pipt_pkg::COUNT_W'(poly_len);
    return r;
  endfunction

  task automatic send_beat(input logic [1:0] code, input int px, input int py,
                           input int ox, input int oy);
    int gap;
    gap = 0;
    if (send_idle_pct > 0)
      while ($urandom_range(99) < send_idle_pct && gap < 12) gap++;
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    x <= px[15:0];
    y <= py[15:0];
    offset_x <= ox[15:0];
    offset_y <= oy[15:0];
    do @(posedge clk); while (in_stall);
    answer_q.push_back(predict_answer(code, $signed(px[15:0]), $signed(py[15:0]),
                                      $signed(ox[15:0]), $signed(oy[15:0])));
  endtask

  // Holds the sender back until every outstanding beat has been answered.
  task automatic wait_for_answers();
    @(negedge clk);
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp16(input int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic int pick_offset();
    int sel;
    sel = $urandom_range(9);
    if (sel < 2) return 0;
    if (sel < 7) return span(-1000, 1000);
    return span(-32768, 32767);
  endfunction

  task automatic test_directed();
    send_beat(pipt_pkg::OP_TEST, 0, 0, 0, 0);
    send_beat(OP_UNUSED, 5, 5, 5, 5);
    send_beat(pipt_pkg::OP_APPEND, -32768, -32768, 0, 0);
    send_beat(pipt_pkg::OP_APPEND, 32767, -32768, 0, 0);
    send_beat(pipt_pkg::OP_APPEND, 32767, 32767, 0, 0);
    send_beat(pipt_pkg::OP_APPEND, -32768, 32767, 0, 0);
    send_beat(pipt_pkg::OP_TEST, 0, 0, 0, 0);
    send_beat(pipt_pkg::OP_TEST, 32767, 0, 0, 0);
    send_beat(pipt_pkg::OP_TEST, -32767, -32767, 0, 0);
    send_beat(pipt_pkg::OP_TEST, 0, 0, 32767, 32767);
    send_beat(pipt_pkg::OP_TEST, 0, 0, -32768, -32768);
    send_beat(pipt_pkg::OP_TEST, 100, -200, -32768, 32767);
    send_beat(OP_UNUSED, -1, -1, -1, -1);
    send_beat(pipt_pkg::OP_CLEAR, 0, 0, 0, 0);
    // After a clear the old box survives but the empty store answers zero.
    send_beat(pipt_pkg::OP_TEST, 0, 0, 0, 0);
    send_beat(pipt_pkg::OP_APPEND, 10, 10, 0, 0);
    send_beat(pipt_pkg::OP_TEST, 10, 10, 0, 0);
    send_beat(pipt_pkg::OP_APPEND, 10, 200, 0, 0);
    send_beat(pipt_pkg::OP_TEST, 10, 100, 0, 0);
    send_beat(pipt_pkg::OP_APPEND, 300, 100, 0, 0);
    send_beat(pipt_pkg::OP_TEST, 100, 100, 0, 0);
    send_beat(pipt_pkg::OP_TEST, 100, 100, 50, -3);
    send_beat(pipt_pkg::OP_TEST, 12, 11, 0, 0);
    wait_for_answers();
  endtask

  task automatic test_store_full();
    send_beat(pipt_pkg::OP_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < pipt_pkg::MAX_VERTICES + 2; i++)
      send_beat(pipt_pkg::OP_APPEND, span(-32768, 32767), span(-32768, 32767), 0, 0);
    repeat (3) send_beat(pipt_pkg::OP_TEST, span(-20000, 20000), span(-20000, 20000),
                         pick_offset(), pick_offset());
    send_beat(pipt_pkg::OP_CLEAR, 0, 0, 0, 0);
  endtask

  task automatic test_random_polygons(input int idle_pct, input int stall_pct,
                                      input int beats);
    int sent, cx, cy, r, n, k, code;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(9) != 0) begin
        send_beat(pipt_pkg::OP_CLEAR, span(-32768, 32767), span(-32768, 32767), 0, 0);
        sent++;
      end
      cx = span(-32768, 32767);
      cy = span(-32768, 32767);
      r = span(1, 20000);
      n = span(1, 12);
      for (int i = 0; i < n; i++) begin
        send_beat(pipt_pkg::OP_APPEND, clamp16(cx + span(-r, r)), clamp16(cy + span(-r, r)),
                  span(-32768, 32767), span(-32768, 32767));
        sent++;
      end
      k = span(2, 6);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(4) != 0 && poly_len > 0 && bmax_x > bmin_x && bmax_y > bmin_y)
          send_beat(pipt_pkg::OP_TEST, span(bmin_x, bmax_x), span(bmin_y, bmax_y),
                    pick_offset(), pick_offset());
        else
          send_beat(pipt_pkg::OP_TEST, span(-32768, 32767), span(-32768, 32767),
                    pick_offset(), pick_offset());
        sent++;
      end
      if ($urandom_range(5) == 0) begin
        code = $urandom_range(3);
        send_beat(code[1:0], span(-32768, 32767), span(-32768, 32767),
                  span(-32768, 32767), span(-32768, 32767));
      end
    end
    wait_for_answers();
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        answer_seen = answer_q.pop_front();
        if (inside_res !== answer_seen.in_poly)
          report_mismatch($sformatf("inside_res %b, expected %b", inside_res,
                                    answer_seen.in_poly));
        if (status !== answer_seen.full_drop)
          report_mismatch($sformatf("status %b, expected %b", status, answer_seen.full_drop));
        if (vertex_count !== answer_seen.held)
          report_mismatch($sformatf("vertex_count %0d, expected %0d", vertex_count,
                                    answer_seen.held));
      end
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    poly_len = 0;
    bmin_x = 0; bmax_x = 0; bmin_y = 0; bmax_y = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    op = pipt_pkg::OP_APPEND;
    x = '0;
    y = '0;
    offset_x = '0;
    offset_y = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_store_full();
    test_random_polygons(0, 0, 120);
    test_random_polygons(77, 0, 120);
    test_random_polygons(0, 77, 120);
    test_random_polygons(38, 38, 120);

    repeat (20) @(posedge clk);
    if (error_count == 0 && answer_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
